// ===== src/morse_code_keyer_core_defines.svh =====
// ----------------------------------------------------------------------------
// morse keyer assertion macros
// shared concurrent assertion forms for the keyer checker
// ----------------------------------------------------------------------------
`ifndef MORSE_CODE_KEYER_CORE_DEFINES_SVH
`define MORSE_CODE_KEYER_CORE_DEFINES_SVH

// check that holds outside reset
`define MCK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also holds through reset
`define MCK_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/mck_pkg.sv =====
// ----------------------------------------------------------------------------
// mck_pkg
// types, constants and code tables of the morse keyer
// ----------------------------------------------------------------------------
package mck_pkg;

  localparam int unsigned MCK_QUEUE_DEPTH = 2;

  localparam int unsigned UNIT_W = 10;
  localparam int unsigned DUR_W  = 13;
  localparam int unsigned CHAR_W = 8;

  localparam logic [UNIT_W-1:0] MCK_UNIT_RESET = 10'd50;

  localparam logic [2:0] UNITS_DOT       = 3'd1;
  localparam logic [2:0] UNITS_DASH      = 3'd3;
  localparam logic [2:0] UNITS_ELEM_GAP  = 3'd1;
  localparam logic [2:0] UNITS_SPACE     = 3'd6;
  localparam logic [2:0] UNITS_CHAR_GAP  = 3'd2;

  localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] ASCII_LOWER_Z = 8'h7a;
  localparam logic [CHAR_W-1:0] ASCII_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] ASCII_SPACE   = 8'h20;

  // pattern bit i set means element i is a dash, element 0 is sent first
  typedef struct packed {
    logic [2:0] len;
    logic [4:0] pattern;
  } mck_code_t;

  typedef struct packed {
    logic      is_space;
    mck_code_t code;
  } mck_desc_t;

  localparam int unsigned MCK_DESC_W = $bits(mck_desc_t);

  typedef struct packed {
    logic full;
    logic empty;
  } mck_qstat_t;

  function automatic mck_code_t letter_code(input logic [4:0] idx);
    mck_code_t c;
    case (idx)
      5'd0:    c = '{len: 3'd2, pattern: 5'b00010};
      5'd1:    c = '{len: 3'd4, pattern: 5'b00001};
      5'd2:    c = '{len: 3'd4, pattern: 5'b00101};
      5'd3:    c = '{len: 3'd3, pattern: 5'b00001};
      5'd4:    c = '{len: 3'd1, pattern: 5'b00000};
      5'd5:    c = '{len: 3'd4, pattern: 5'b00100};
      5'd6:    c = '{len: 3'd3, pattern: 5'b00011};
      5'd7:    c = '{len: 3'd4, pattern: 5'b00000};
      5'd8:    c = '{len: 3'd2, pattern: 5'b00000};
      5'd9:    c = '{len: 3'd4, pattern: 5'b01110};
      5'd10:   c = '{len: 3'd3, pattern: 5'b00101};
      5'd11:   c = '{len: 3'd4, pattern: 5'b00010};
      5'd12:   c = '{len: 3'd2, pattern: 5'b00011};
      5'd13:   c = '{len: 3'd2, pattern: 5'b00001};
      5'd14:   c = '{len: 3'd3, pattern: 5'b00111};
      5'd15:   c = '{len: 3'd4, pattern: 5'b00110};
      5'd16:   c = '{len: 3'd4, pattern: 5'b01011};
      5'd17:   c = '{len: 3'd3, pattern: 5'b00010};
      5'd18:   c = '{len: 3'd3, pattern: 5'b00000};
      5'd19:   c = '{len: 3'd1, pattern: 5'b00001};
      5'd20:   c = '{len: 3'd3, pattern: 5'b00100};
      5'd21:   c = '{len: 3'd4, pattern: 5'b01000};
      5'd22:   c = '{len: 3'd3, pattern: 5'b00110};
      5'd23:   c = '{len: 3'd4, pattern: 5'b01001};
      5'd24:   c = '{len: 3'd4, pattern: 5'b01101};
      5'd25:   c = '{len: 3'd4, pattern: 5'b00011};
      default: c = '{len: 3'd0, pattern: 5'b00000};
    endcase
    return c;
  endfunction

  function automatic mck_code_t digit_code(input logic [3:0] idx);
    mck_code_t c;
    case (idx)
      4'd0:    c = '{len: 3'd5, pattern: 5'b11111};
      4'd1:    c = '{len: 3'd5, pattern: 5'b11110};
      4'd2:    c = '{len: 3'd5, pattern: 5'b11100};
      4'd3:    c = '{len: 3'd5, pattern: 5'b11000};
      4'd4:    c = '{len: 3'd5, pattern: 5'b10000};
      4'd5:    c = '{len: 3'd5, pattern: 5'b00000};
      4'd6:    c = '{len: 3'd5, pattern: 5'b00001};
      4'd7:    c = '{len: 3'd5, pattern: 5'b00011};
      4'd8:    c = '{len: 3'd5, pattern: 5'b00111};
      4'd9:    c = '{len: 3'd5, pattern: 5'b01111};
      default: c = '{len: 3'd0, pattern: 5'b00000};
    endcase
    return c;
  endfunction

endpackage

// ===== src/mck_front.sv =====
// ----------------------------------------------------------------------------
// mck_front
// accepts characters and classifies them into element descriptors
// ----------------------------------------------------------------------------
module mck_front
  import mck_pkg::*;
(
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CHAR_W-1:0] in_character,
  input  mck_qstat_t        qstat,
  output logic              push,
  output mck_desc_t         push_desc
);

  logic              is_letter;
  logic              is_digit;
  logic [CHAR_W-1:0] letter_off;
  logic [CHAR_W-1:0] digit_off;

  assign in_ready = !qstat.full;
  assign push     = in_valid && in_ready;

  assign is_letter  = (in_character >= ASCII_LOWER_A) && (in_character <= ASCII_LOWER_Z);
  assign is_digit   = (in_character >= ASCII_ZERO) && (in_character <= ASCII_NINE);
  assign letter_off = in_character - ASCII_LOWER_A;
  assign digit_off  = in_character - ASCII_ZERO;

  always_comb begin
    push_desc.is_space = (in_character == ASCII_SPACE);
    if (is_letter) begin
      push_desc.code = letter_code(letter_off[4:0]);
    end else if (is_digit) begin
      push_desc.code = digit_code(digit_off[3:0]);
    end else begin
      push_desc.code = '{len: 3'd0, pattern: 5'b00000};
    end
  end

endmodule

// ===== src/mck_queue.sv =====
// ----------------------------------------------------------------------------
// mck_queue
// small descriptor queue between the front and the back sequencer
// ----------------------------------------------------------------------------
module mck_queue
  import mck_pkg::*;
#(
  parameter int unsigned WIDTH = MCK_DESC_W,
  parameter int unsigned DEPTH = MCK_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output mck_qstat_t       qstat
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign qstat.full  = (count_r == CW'(DEPTH));
  assign qstat.empty = (count_r == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign pop_data    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== src/mck_back.sv =====
// ----------------------------------------------------------------------------
// mck_back
// segment sequencer with registered output word
// ----------------------------------------------------------------------------
module mck_back
  import mck_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [UNIT_W-1:0] unit_time_ms,
  input  mck_qstat_t        qstat,
  input  mck_desc_t         pop_desc,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_key_on,
  output logic [DUR_W-1:0]  out_duration_ms,
  output logic              out_last_segment
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ELEM  = 5'b00010,
    ST_EOFF  = 5'b00100,
    ST_SPACE = 5'b01000,
    ST_GAP   = 5'b10000
  } mck_state_t;

  mck_state_t       state_r, state_nxt;
  logic [2:0]       len_r, len_nxt;
  logic [4:0]       pat_r, pat_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             key_r;
  logic [DUR_W-1:0] dur_r;
  logic             last_r;
  logic             load_ok;
  logic             emit;
  logic             seg_key;
  logic [2:0]       seg_units;
  logic             seg_last;
  logic [DUR_W-1:0] seg_dur;

  assign load_ok = !out_valid_r || out_ready;
  assign seg_dur = DUR_W'(seg_units) * DUR_W'(unit_time_ms);

  always_comb begin
    state_nxt = state_r;
    len_nxt   = len_r;
    pat_nxt   = pat_r;
    pop       = 1'b0;
    emit      = 1'b0;
    seg_key   = 1'b0;
    seg_units = UNITS_CHAR_GAP;
    seg_last  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!qstat.empty) begin
          pop     = 1'b1;
          len_nxt = pop_desc.code.len;
          pat_nxt = pop_desc.code.pattern;
          if (pop_desc.code.len != 3'd0) begin
            state_nxt = ST_ELEM;
          end else if (pop_desc.is_space) begin
            state_nxt = ST_SPACE;
          end else begin
            state_nxt = ST_GAP;
          end
        end
      end
      ST_ELEM: begin
        if (load_ok) begin
          emit      = 1'b1;
          seg_key   = 1'b1;
          seg_units = pat_r[0] ? UNITS_DASH : UNITS_DOT;
          state_nxt = ST_EOFF;
        end
      end
      ST_EOFF: begin
        if (load_ok) begin
          emit      = 1'b1;
          seg_units = UNITS_ELEM_GAP;
          pat_nxt   = pat_r >> 1;
          len_nxt   = len_r - 3'd1;
          state_nxt = (len_r == 3'd1) ? ST_GAP : ST_ELEM;
        end
      end
      ST_SPACE: begin
        if (load_ok) begin
          emit      = 1'b1;
          seg_units = UNITS_SPACE;
          state_nxt = ST_GAP;
        end
      end
      ST_GAP: begin
        if (load_ok) begin
          emit      = 1'b1;
          seg_units = UNITS_CHAR_GAP;
          seg_last  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r <= len_nxt;
    pat_r <= pat_nxt;
    if (emit) begin
      key_r  <= seg_key;
      dur_r  <= seg_dur;
      last_r <= seg_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_key_on       = key_r;
  assign out_duration_ms  = dur_r;
  assign out_last_segment = last_r;

endmodule

// ===== src/morse_code_keyer_core.sv =====
// ----------------------------------------------------------------------------
// morse_code_keyer_core
// turns ascii characters into timed morse keying segments
// ----------------------------------------------------------------------------
// Each accepted character word produces a run of output words, one per keying
// segment (key level, duration in ms, last flag). The back sequencer emits at
// most one segment per cycle unless out_ready holds the output word back, and
// passes through its idle state to take each character from the queue.
// Characters are taken while the small queue has room. The unit time register
// is written through the cfg port, which is always ready, and should change
// only while the keyer is idle.
module morse_code_keyer_core
  import mck_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = MCK_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CHAR_W-1:0] in_character,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_key_on,
  output logic [DUR_W-1:0]  out_duration_ms,
  output logic              out_last_segment,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [UNIT_W-1:0] cfg_unit_time_ms
);

  logic [UNIT_W-1:0] unit_r;
  mck_qstat_t        qstat;
  logic              push;
  mck_desc_t         push_desc;
  logic              pop;
  logic [MCK_DESC_W-1:0] pop_bits;
  mck_desc_t         pop_desc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_r <= MCK_UNIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unit_r <= cfg_unit_time_ms;
    end
  end

  mck_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_character (in_character),
    .qstat        (qstat),
    .push         (push),
    .push_desc    (push_desc)
  );

  mck_queue #(
    .WIDTH (MCK_DESC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_desc),
    .pop       (pop),
    .pop_data  (pop_bits),
    .qstat     (qstat)
  );

  assign pop_desc = mck_desc_t'(pop_bits);

  mck_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .unit_time_ms     (unit_r),
    .qstat            (qstat),
    .pop_desc         (pop_desc),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_key_on       (out_key_on),
    .out_duration_ms  (out_duration_ms),
    .out_last_segment (out_last_segment)
  );

endmodule

// ===== src/mck_checker.sv =====
// ----------------------------------------------------------------------------
// mck_checker
// port level checks for the morse keyer, bound to the top level
// ----------------------------------------------------------------------------
`include "morse_code_keyer_core_defines.svh"

module mck_checker
  import mck_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [CHAR_W-1:0] in_character,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_key_on,
  input logic [DUR_W-1:0]  out_duration_ms,
  input logic              out_last_segment
);

  `MCK_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid, "out_valid after reset")
  `MCK_ASSERT(a_last_is_off, out_valid |-> !(out_last_segment && out_key_on), "last word keyed")
  `MCK_ASSERT(a_on_then_off, (out_valid && out_ready && out_key_on) |=> !(out_valid && out_key_on), "two keyed words in a row")
  `MCK_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_key_on) && $stable(out_duration_ms) && $stable(out_last_segment)), "stalled output word changed")
  `MCK_ASSERT(a_in_hold, (in_valid && !in_ready) |=> (in_valid && $stable(in_character)), "waiting input word changed")

endmodule

bind morse_code_keyer_core mck_checker u_mck_checker (.*);
